/* hw/rtl/humidity_sensor_two_wire_master_core_defines.svh */
// assertion macros for the two-wire sensor master checker
// no dependencies; included by the checker file
`ifndef HUMIDITY_SENSOR_TWO_WIRE_MASTER_CORE_DEFINES_SVH
`define HUMIDITY_SENSOR_TWO_WIRE_MASTER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define HSTW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define HSTW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/hstw_pkg.sv */
// shared constants and helpers for the two-wire sensor master
// no dependencies; used by the core and its checker
package hstw_pkg;

  localparam int WAIT_BITS_DEF    = 20;
  localparam int RESET_CLOCKS_DEF = 9;

  localparam int WL_W = 20;
  localparam logic [WL_W-1:0] WAIT_LIMIT_RST = 20'd250000;

  // register map
  localparam logic REG_WAIT_LIMIT = 1'b0;
  localparam logic REG_CRC_EN     = 1'b1;

  // request codes
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_TEMP   = 2'd1;
  localparam logic [1:0] ACT_HUMID  = 2'd2;
  localparam logic [1:0] ACT_STATUS = 2'd3;

  // sensor commands
  localparam logic [7:0] CMD_TEMP   = 8'h03;
  localparam logic [7:0] CMD_HUMID  = 8'h05;
  localparam logic [7:0] CMD_STATUS = 8'h07;

  localparam logic [7:0] CRC_POLY = 8'h31;

  // error codes
  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_NACK    = 2'd1;
  localparam logic [1:0] ERR_TIMEOUT = 2'd2;
  localparam logic [1:0] ERR_CRC     = 2'd3;

  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] a;
    a = acc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (a[7]) begin
        a = {a[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        a = {a[6:0], 1'b0};
      end
    end
    return a;
  endfunction

  function automatic logic [7:0] flip8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

  function automatic logic [7:0] command_of(input logic [1:0] kind);
    logic [7:0] c;
    case (kind)
      ACT_TEMP:  c = CMD_TEMP;
      ACT_HUMID: c = CMD_HUMID;
      default:   c = CMD_STATUS;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/humidity_sensor_two_wire_master_core.sv */
// two-wire humidity/temperature sensor master, one bus phase per transaction
// depends on hstw_pkg
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+--------------------------------------------
//   in       | to core   | in_valid/in_ready  | in_action, in_sda_in
//   out      | from core | out_valid/out_ready| scl_level, sda_pull_low, busy, done, err, value
//   config   | to core   | apb psel/penable   | wait_limit (0x0), crc_check_enable (0x4)
//
// every input transaction yields exactly one result, in the cycle after acceptance
// a new transaction is taken every cycle while the output is not stalled; the bus sequencer
// step is a single pass between the sequencer state and the result register
// in_ready drops only while a result sits in the output register and out_ready is low
// rst_n is synchronous; it clears the sequencer to idle and restores register defaults
module humidity_sensor_two_wire_master_core #(
  parameter int WAIT_BITS    = hstw_pkg::WAIT_BITS_DEF,
  parameter int RESET_CLOCKS = hstw_pkg::RESET_CLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic        in_sda_in,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_scl_level,
  output logic        out_sda_pull_low,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [1:0]  out_error_code,
  output logic [15:0] out_value,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hstw_pkg::*;

  // compare width covers both the limit register and the poll counter
  localparam int CW = (WAIT_BITS > WL_W) ? WAIT_BITS : WL_W;
  localparam logic [CW-1:0] MAXC = CW'((64'd1 << WAIT_BITS) - 64'd1);

  typedef enum logic [4:0] {
    PH_IDLE, PH_S0, PH_S1, PH_S2, PH_S3, PH_S4, PH_S5,
    PH_WLO, PH_WHI, PH_ALO, PH_AHI, PH_WAIT,
    PH_RC0, PH_RCHI, PH_RCLO, PH_FIN, PH_RD
  } phase_t;

  // config registers
  logic [WL_W-1:0] wait_limit_r;
  logic            crc_en_r;

  // sequencer state
  phase_t                 phase_r, phase_nxt;
  logic [1:0]             slot_r, slot_nxt;       // byte slot within the read section
  logic [1:0]             sub_r, sub_nxt;         // quarter within a read bit/ack
  logic [3:0]             bit_index_r, bit_index_nxt;
  logic [7:0]             shift_byte_r, shift_byte_nxt;
  logic [7:0]             crc_accum_r, crc_accum_nxt;
  logic [7:0]             high_byte_r, high_byte_nxt;
  logic [7:0]             low_byte_r, low_byte_nxt;
  logic [WAIT_BITS-1:0]   wait_count_r, wait_count_nxt;
  logic [1:0]             request_kind_r, request_kind_nxt;
  logic [1:0]             pending_error_r, pending_error_nxt;

  // result register
  logic        out_valid_r;
  logic        scl_r, pull_r, busy_r, done_r;
  logic [1:0]  err_r;
  logic [15:0] value_r;

  // step outputs
  logic        scl_c, pull_c, done_c;
  logic [1:0]  err_c;
  logic [15:0] val_c;

  // helpers
  logic            accept;
  logic            cfg_wr;
  logic            is_status;
  logic            data_slot;
  logic [7:0]      shifted_in;
  logic [CW-1:0]   lim_raw, lim;
  logic [WAIT_BITS-1:0] cnt_inc;
  logic [4:0]      rc_next;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;

  assign out_valid        = out_valid_r;
  assign out_scl_level    = scl_r;
  assign out_sda_pull_low = pull_r;
  assign out_busy_res     = busy_r;
  assign out_done_res     = done_r;
  assign out_error_code   = err_r;
  assign out_value        = value_r;

  // register readback
  always_comb begin
    case (paddr[2])
      REG_WAIT_LIMIT: prdata = {{(32-WL_W){1'b0}}, wait_limit_r};
      REG_CRC_EN:     prdata = {31'd0, crc_en_r};
      default:        prdata = 32'd0;
    endcase
  end

  // status reads carry one data byte, measurements two
  assign is_status  = (request_kind_r == ACT_STATUS);
  assign data_slot  = is_status ? (slot_r == 2'd0) : (slot_r != 2'd2);
  assign shifted_in = {shift_byte_r[6:0], in_sda_in};

  // poll limit: zero acts as one, saturates at the counter range
  assign lim_raw = (wait_limit_r == '0) ? CW'(1) : CW'(wait_limit_r);
  assign lim     = (lim_raw > MAXC) ? MAXC : lim_raw;
  assign cnt_inc = (wait_count_r != '1) ? wait_count_r + 1'b1 : wait_count_r;
  assign rc_next = {1'b0, bit_index_r} + 5'd1;

  // one bus phase
  always_comb begin
    phase_nxt         = phase_r;
    slot_nxt          = slot_r;
    sub_nxt           = sub_r;
    bit_index_nxt     = bit_index_r;
    shift_byte_nxt    = shift_byte_r;
    crc_accum_nxt     = crc_accum_r;
    high_byte_nxt     = high_byte_r;
    low_byte_nxt      = low_byte_r;
    wait_count_nxt    = wait_count_r;
    request_kind_nxt  = request_kind_r;
    pending_error_nxt = pending_error_r;
    scl_c  = 1'b0;
    pull_c = 1'b0;
    done_c = 1'b0;
    err_c  = ERR_OK;
    val_c  = 16'd0;

    case (phase_r)
      // start pattern
      PH_S0: phase_nxt = PH_S1;
      PH_S1: begin
        scl_c = 1'b1;
        phase_nxt = PH_S2;
      end
      PH_S2: begin
        scl_c = 1'b1;
        pull_c = 1'b1;
        phase_nxt = PH_S3;
      end
      PH_S3: begin
        pull_c = 1'b1;
        phase_nxt = PH_S4;
      end
      PH_S4: begin
        scl_c = 1'b1;
        pull_c = 1'b1;
        phase_nxt = PH_S5;
      end
      PH_S5: begin
        scl_c = 1'b1;
        bit_index_nxt = 4'd0;
        phase_nxt = (pending_error_r != ERR_OK) ? PH_FIN : PH_WLO;
      end
      // command byte, msb first
      PH_WLO: begin
        pull_c = !shift_byte_r[7];
        phase_nxt = PH_WHI;
      end
      PH_WHI: begin
        scl_c = 1'b1;
        pull_c = !shift_byte_r[7];
        shift_byte_nxt = {shift_byte_r[6:0], 1'b0};
        if (bit_index_r >= 4'd7) begin
          bit_index_nxt = 4'd0;
          phase_nxt = PH_ALO;
        end else begin
          bit_index_nxt = bit_index_r + 4'd1;
          phase_nxt = PH_WLO;
        end
      end
      // sensor acknowledge
      PH_ALO: phase_nxt = PH_AHI;
      PH_AHI: begin
        scl_c = 1'b1;
        if (in_sda_in) begin
          pending_error_nxt = ERR_NACK;
          phase_nxt = PH_RC0;
        end else if (is_status) begin
          shift_byte_nxt = 8'd0;
          bit_index_nxt = 4'd0;
          slot_nxt = 2'd0;
          sub_nxt = 2'd0;
          phase_nxt = PH_RD;
        end else begin
          wait_count_nxt = '0;
          phase_nxt = PH_WAIT;
        end
      end
      // poll for conversion done
      PH_WAIT: begin
        if (!in_sda_in) begin
          shift_byte_nxt = 8'd0;
          bit_index_nxt = 4'd0;
          slot_nxt = 2'd0;
          sub_nxt = 2'd0;
          phase_nxt = PH_RD;
        end else begin
          wait_count_nxt = cnt_inc;
          if (CW'(cnt_inc) >= lim) begin
            pending_error_nxt = ERR_TIMEOUT;
            phase_nxt = PH_RC0;
          end
        end
      end
      // read section: each bit uses quarters 0 and 1, after the eighth bit quarters 2 and 3 are the ack slot
      PH_RD: begin
        case (sub_r)
          2'd0: sub_nxt = 2'd1;
          2'd1: begin
            scl_c = 1'b1;
            shift_byte_nxt = shifted_in;
            if (bit_index_r >= 4'd7) begin
              bit_index_nxt = 4'd0;
              if (data_slot) begin
                if (is_status || slot_r == 2'd1) begin
                  low_byte_nxt = shifted_in;
                end else begin
                  high_byte_nxt = shifted_in;
                end
                crc_accum_nxt = crc8_step(crc_accum_r, shifted_in);
              end
              sub_nxt = 2'd2;
            end else begin
              bit_index_nxt = bit_index_r + 4'd1;
              sub_nxt = 2'd0;
            end
          end
          2'd2: begin
            pull_c = data_slot;
            sub_nxt = 2'd3;
          end
          default: begin
            scl_c = 1'b1;
            pull_c = data_slot;
            if (data_slot && slot_r != 2'd2) begin
              shift_byte_nxt = 8'd0;
              bit_index_nxt = 4'd0;
              slot_nxt = slot_r + 2'd1;
              sub_nxt = 2'd0;
            end else if (!crc_en_r || crc_accum_r == flip8(shift_byte_r)) begin
              done_c = 1'b1;
              val_c = is_status ? {8'd0, low_byte_r} : {high_byte_r, low_byte_r};
              phase_nxt = PH_IDLE;
            end else begin
              pending_error_nxt = ERR_CRC;
              phase_nxt = PH_RC0;
            end
          end
        endcase
      end
      // recovery: clock pulses with data released, then start pattern
      PH_RC0: begin
        bit_index_nxt = 4'd0;
        phase_nxt = PH_RCHI;
      end
      PH_RCHI: begin
        scl_c = 1'b1;
        phase_nxt = PH_RCLO;
      end
      PH_RCLO: begin
        if (rc_next >= 5'(RESET_CLOCKS)) begin
          bit_index_nxt = 4'd0;
          phase_nxt = PH_S0;
        end else begin
          bit_index_nxt = rc_next[3:0];
          phase_nxt = PH_RCHI;
        end
      end
      PH_FIN: begin
        done_c = 1'b1;
        err_c = pending_error_r;
        pending_error_nxt = ERR_OK;
        phase_nxt = PH_IDLE;
      end
      default: begin
        // idle: take a new request, ticks do nothing
        phase_nxt = PH_IDLE;
        if (in_action != ACT_TICK) begin
          request_kind_nxt  = in_action;
          pending_error_nxt = ERR_OK;
          wait_count_nxt    = '0;
          bit_index_nxt     = 4'd0;
          high_byte_nxt     = 8'd0;
          low_byte_nxt      = 8'd0;
          shift_byte_nxt    = command_of(in_action);
          crc_accum_nxt     = crc8_step(8'd0, command_of(in_action));
          phase_nxt         = PH_S1;
        end
      end
    endcase
  end

  // sequencer state, config and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      slot_r          <= 2'd0;
      sub_r           <= 2'd0;
      bit_index_r     <= 4'd0;
      shift_byte_r    <= 8'd0;
      crc_accum_r     <= 8'd0;
      high_byte_r     <= 8'd0;
      low_byte_r      <= 8'd0;
      wait_count_r    <= '0;
      request_kind_r  <= 2'd0;
      pending_error_r <= ERR_OK;
      wait_limit_r    <= WAIT_LIMIT_RST;
      crc_en_r        <= 1'b1;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[2])
          REG_WAIT_LIMIT: wait_limit_r <= pwdata[WL_W-1:0];
          REG_CRC_EN:     crc_en_r <= pwdata[0];
          default:        ;
        endcase
      end
      if (accept) begin
        phase_r         <= phase_nxt;
        slot_r          <= slot_nxt;
        sub_r           <= sub_nxt;
        bit_index_r     <= bit_index_nxt;
        shift_byte_r    <= shift_byte_nxt;
        crc_accum_r     <= crc_accum_nxt;
        high_byte_r     <= high_byte_nxt;
        low_byte_r      <= low_byte_nxt;
        wait_count_r    <= wait_count_nxt;
        request_kind_r  <= request_kind_nxt;
        pending_error_r <= pending_error_nxt;
        out_valid_r     <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    // result payload, no reset needed
    if (accept) begin
      scl_r   <= scl_c;
      pull_r  <= pull_c;
      busy_r  <= (phase_nxt != PH_IDLE);
      done_r  <= done_c;
      err_r   <= err_c;
      value_r <= val_c;
    end
  end

endmodule

/* hw/rtl/hstw_checker.sv */
// port-level checks for the two-wire sensor master core, bound into the core module
// depends on hstw_pkg and humidity_sensor_two_wire_master_core_defines.svh
`include "humidity_sensor_two_wire_master_core_defines.svh"

module hstw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_scl_level,
  input logic        out_sda_pull_low,
  input logic        out_busy_res,
  input logic        out_done_res,
  input logic [1:0]  out_error_code,
  input logic [15:0] out_value
);
  import hstw_pkg::*;

  // a stalled result holds
  `HSTW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_done_res), "stalled result changed")

  // error code only on the finishing phase
  `HSTW_ASSERT_NOW(a_err_only_done, out_valid && !out_done_res, out_error_code == ERR_OK, "error code without done")

  // data only on a clean finish
  `HSTW_ASSERT_NOW(a_value_clean, out_valid && (!out_done_res || out_error_code != ERR_OK), out_value == 16'd0, "value on failed or unfinished transaction")

  // a finished transaction leaves the core idle
  `HSTW_ASSERT_NOW(a_done_idle, out_valid && out_done_res, !out_busy_res, "busy after done")

  // clean finish on a clock-high phase, error finish on a clock-low phase, data released
  `HSTW_ASSERT_NOW(a_done_levels, out_valid && out_done_res, !out_sda_pull_low && (out_scl_level == (out_error_code == ERR_OK)), "bus levels wrong on finish")

endmodule

bind humidity_sensor_two_wire_master_core hstw_checker u_hstw_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_scl_level    (out_scl_level),
  .out_sda_pull_low (out_sda_pull_low),
  .out_busy_res     (out_busy_res),
  .out_done_res     (out_done_res),
  .out_error_code   (out_error_code),
  .out_value        (out_value)
);
